// File: src/hptc_pkg.sv
`default_nettype none
package hptc_pkg;

  typedef struct packed {
    logic [15:0] raw_humid;
    logic [23:0] raw_press;
    logic [23:0] raw_temp;
  } in_item_t;

  typedef struct packed {
    logic        humid_valid;
    logic [16:0] humid_q10;
    logic        press_div_zero;
    logic        press_valid;
    logic signed [31:0] press_q8;
    logic        temp_valid;
    logic signed [31:0] temp_centi;
  } out_item_t;

  localparam logic [2:0] REG_TEMP       = 3'd0;
  localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
  localparam logic [2:0] REG_PRESS_HIGH = 3'd2;
  localparam logic [2:0] REG_MIXED      = 3'd3;
  localparam logic [2:0] REG_HUMID      = 3'd4;

  localparam logic [23:0] TEMP_OFF_MARK  = 24'h800000;
  localparam logic [23:0] PRESS_OFF_MARK = 24'h800000;
  localparam logic [15:0] HUMID_OFF_MARK = 16'h8000;
  localparam logic [31:0] HUMID_MAX      = 32'd419430400;
  localparam logic [16:0] HUMID_Q10_MAX  = 17'd102400;

endpackage
`default_nettype wire

// File: src/hptc_mul.sv
`default_nettype none
// 64 x 64 multiplier keeping the low 64 bits, built from one 32 x 32
// multiplier used for three partial products in turn.
module hptc_mul import hptc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      p
);

  logic [63:0] a_r, b_r, prod, acc;
  logic [1:0]  cnt;
  logic        busy;
  logic [31:0] ma, mb;

  always_comb begin
    unique case (cnt)
      2'd0: begin ma = a_r[31:0];  mb = b_r[31:0];  end
      2'd1: begin ma = a_r[31:0];  mb = b_r[63:32]; end
      default: begin ma = a_r[63:32]; mb = b_r[31:0]; end
    endcase
  end

  assign p = acc;

  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (cnt == 2'd3);
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      a_r  <= a;
      b_r  <= b;
      acc  <= '0;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      prod <= 64'(ma) * 64'(mb);
      if (cnt == 2'd1) begin
        acc <= acc + prod;
      end else if (cnt != 2'd0) begin
        acc <= acc + {prod[31:0], 32'b0};
      end
      cnt <= cnt + 2'd1;
      if (cnt == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/hptc_div.sv
`default_nettype none
// Signed 64-bit division truncating toward zero, one quotient bit a cycle.
module hptc_div import hptc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             done,
  output logic [63:0]      quot
);

  logic [63:0] q, r, d;
  logic [5:0]  cnt;
  logic        busy, neg;
  logic [64:0] rs;

  assign rs   = {r, q[63]};
  assign quot = neg ? (64'd0 - q) : q;

  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (cnt == 6'd63);
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      neg  <= num[63] ^ den[63];
      q    <= num[63] ? (64'd0 - num) : num;
      d    <= den[63] ? (64'd0 - den) : den;
      r    <= '0;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (rs >= {1'b0, d}) begin
        r <= 64'(rs - {1'b0, d});
        q <= {q[62:0], 1'b1};
      end else begin
        r <= rs[63:0];
        q <= {q[62:0], 1'b0};
      end
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/humidity_pressure_temp_compensation.sv
// Each multiply runs on the shared 32x32 multiplier and pressure uses one
// division; skipped readings skip their multiplies and the division.
// Input: a new item is taken once the previous one leaves the sequencer,
// while its result may still wait at the output.
// Reset: synchronous; coefficient registers and the fine temperature clear.
`default_nettype none
module humidity_pressure_temp_compensation import hptc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE, S_T_A, S_T_B, S_T_C, S_T_D,
    S_P_INIT, S_P_A, S_P_B, S_P_C, S_P_D, S_P_E, S_P_F, S_P_CHK, S_P_G, S_P_DIV,
    S_P_H, S_P_I, S_P_J, S_P_SUM, S_P_FIN, S_P_SAT,
    S_H_INIT, S_H_A, S_H_B, S_H_C, S_H_D, S_H_E, S_H_F, S_H_G, S_H_H, S_H_CLAMP,
    S_DONE
  } state_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] s);
    return 32'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] s);
    return 64'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  state_t      state;
  logic [47:0] temp_coeffs, mixed_coeffs;
  logic [63:0] press_coeffs_low, press_coeffs_high;
  logic [31:0] humid_coeffs;
  logic [31:0] fine_temp;
  logic [23:0] rt, rp;
  logic [15:0] rh;
  out_item_t   res;
  logic        issued;

  logic [31:0] tv1, tb, hx, hy, hz, hw, hv;
  logic [63:0] w_v1, w_sq, w_v2, w_a, w_p;

  logic [63:0] mul_a, mul_b, mul_p, div_q;
  logic        mul_start, mul_done, div_start, div_done, is_mul;
  logic [31:0] m32;

  // Coefficient fields.
  logic [15:0] t1, t2, t3, p1;
  logic [63:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic [7:0]  h1, h3, h6;
  logic [15:0] h2;
  logic [11:0] h4, h5;
  logic [19:0] t_adc, p_adc;
  logic [31:0] ta, tbase;
  logic [63:0] q13;

  assign t1 = temp_coeffs[15:0];
  assign t2 = temp_coeffs[31:16];
  assign t3 = temp_coeffs[47:32];
  assign p1 = press_coeffs_low[15:0];
  assign p2 = sx16(press_coeffs_low[31:16]);
  assign p3 = sx16(press_coeffs_low[47:32]);
  assign p4 = sx16(press_coeffs_low[63:48]);
  assign p5 = sx16(press_coeffs_high[15:0]);
  assign p6 = sx16(press_coeffs_high[31:16]);
  assign p7 = sx16(press_coeffs_high[47:32]);
  assign p8 = sx16(press_coeffs_high[63:48]);
  assign p9 = sx16(mixed_coeffs[15:0]);
  assign h1 = mixed_coeffs[23:16];
  assign h2 = mixed_coeffs[39:24];
  assign h3 = mixed_coeffs[47:40];
  assign h4 = humid_coeffs[11:0];
  assign h5 = humid_coeffs[23:12];
  assign h6 = humid_coeffs[31:24];

  assign t_adc = rt[23:4];
  assign p_adc = rp[23:4];
  assign ta    = 32'(t_adc[19:3]) - 32'({t1, 1'b0});
  assign tbase = 32'(t_adc[19:4]) - 32'(t1);
  assign q13   = asr64(w_p, 6'd13);
  assign m32   = mul_p[31:0];

  // Operand selection for the shared multiplier. The 32-bit steps use only
  // the low half of the product, so their operands need correct bits up to
  // bit 31 only; narrower signed coefficients are sign extended.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    is_mul = 1'b1;
    unique case (state)
      S_T_A: begin mul_a = 64'(ta);    mul_b = sx16(t2); end
      S_T_B: begin mul_a = 64'(tbase); mul_b = 64'(tbase); end
      S_T_C: begin mul_a = 64'(tb);    mul_b = sx16(t3); end
      S_T_D: begin mul_a = 64'(fine_temp); mul_b = 64'd5; end
      S_P_A: begin mul_a = w_v1; mul_b = w_v1; end
      S_P_B: begin mul_a = w_sq; mul_b = p6; end
      S_P_C: begin mul_a = w_v1; mul_b = p5; end
      S_P_D: begin mul_a = w_sq; mul_b = p3; end
      S_P_E: begin mul_a = w_v1; mul_b = p2; end
      S_P_F: begin mul_a = w_a;  mul_b = 64'(p1); end
      S_P_G: begin mul_a = w_sq; mul_b = 64'd3125; end
      S_P_H: begin mul_a = p9;   mul_b = q13; end
      S_P_I: begin mul_a = w_a;  mul_b = q13; end
      S_P_J: begin mul_a = p8;   mul_b = w_p; end
      S_H_A: begin mul_a = {{52{h5[11]}}, h5}; mul_b = 64'(hv); end
      S_H_B: begin mul_a = 64'(hv); mul_b = {{56{h6[7]}}, h6}; end
      S_H_C: begin mul_a = 64'(hv); mul_b = 64'(h3); end
      S_H_D: begin mul_a = 64'(hy); mul_b = 64'(hz); end
      S_H_E: begin mul_a = 64'(hw); mul_b = sx16(h2); end
      S_H_F: begin mul_a = 64'(hx); mul_b = 64'(hw); end
      S_H_G: begin
        mul_a = 64'(asr32(hv, 5'd15));
        mul_b = 64'(asr32(hv, 5'd15));
      end
      S_H_H: begin mul_a = 64'(hy); mul_b = 64'(h1); end
      default: is_mul = 1'b0;
    endcase
  end

  assign mul_start = is_mul && !issued;
  assign div_start = (state == S_P_DIV) && !issued;
  assign in_ready  = (state == S_IDLE);

  hptc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  hptc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (w_sq),
    .den   (w_v1),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      mixed_coeffs      <= '0;
      humid_coeffs      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP:       temp_coeffs       <= cfg_data[47:0];
        REG_PRESS_LOW:  press_coeffs_low  <= cfg_data;
        REG_PRESS_HIGH: press_coeffs_high <= cfg_data;
        REG_MIXED:      mixed_coeffs      <= cfg_data[47:0];
        REG_HUMID:      humid_coeffs      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      fine_temp <= '0;
    end else begin
      if (mul_start || div_start) begin
        issued <= 1'b1;
      end else if (mul_done || div_done) begin
        issued <= 1'b0;
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: if (in_valid) begin
          rt  <= in_data.raw_temp;
          rp  <= in_data.raw_press;
          rh  <= in_data.raw_humid;
          res <= '0;
          state <= (in_data.raw_temp != TEMP_OFF_MARK) ? S_T_A : S_P_INIT;
        end
        S_T_A: if (mul_done) begin
          tv1 <= asr32(m32, 5'd11);
          state <= S_T_B;
        end
        S_T_B: if (mul_done) begin
          tb <= asr32(m32, 5'd12);
          state <= S_T_C;
        end
        S_T_C: if (mul_done) begin
          fine_temp <= tv1 + asr32(m32, 5'd14);
          state <= S_T_D;
        end
        S_T_D: if (mul_done) begin
          res.temp_centi <= asr32(m32 + 32'd128, 5'd8);
          res.temp_valid <= 1'b1;
          state <= S_P_INIT;
        end
        S_P_INIT: begin
          if (rp == PRESS_OFF_MARK) begin
            state <= S_H_INIT;
          end else begin
            w_v1  <= {{32{fine_temp[31]}}, fine_temp} - 64'd128000;
            state <= S_P_A;
          end
        end
        S_P_A: if (mul_done) begin
          w_sq <= mul_p;
          state <= S_P_B;
        end
        S_P_B: if (mul_done) begin
          w_v2 <= mul_p;
          state <= S_P_C;
        end
        S_P_C: if (mul_done) begin
          w_v2 <= w_v2 + (mul_p << 17) + (p4 << 35);
          state <= S_P_D;
        end
        S_P_D: if (mul_done) begin
          w_a <= asr64(mul_p, 6'd8);
          state <= S_P_E;
        end
        S_P_E: if (mul_done) begin
          w_a <= (64'd1 << 47) + w_a + (mul_p << 12);
          state <= S_P_F;
        end
        S_P_F: if (mul_done) begin
          w_v1 <= asr64(mul_p, 6'd33);
          res.press_valid <= 1'b1;
          state <= S_P_CHK;
        end
        S_P_CHK: begin
          if (w_v1 == 64'd0) begin
            res.press_div_zero <= 1'b1;
            state <= S_H_INIT;
          end else begin
            w_sq  <= ((64'd1048576 - 64'(p_adc)) << 31) - w_v2;
            state <= S_P_G;
          end
        end
        S_P_G: if (mul_done) begin
          w_sq <= mul_p;
          state <= S_P_DIV;
        end
        S_P_DIV: if (div_done) begin
          w_p <= div_q;
          state <= S_P_H;
        end
        S_P_H: if (mul_done) begin
          w_a <= mul_p;
          state <= S_P_I;
        end
        S_P_I: if (mul_done) begin
          w_v1 <= asr64(mul_p, 6'd25);
          state <= S_P_J;
        end
        S_P_J: if (mul_done) begin
          w_v2 <= asr64(mul_p, 6'd19);
          state <= S_P_SUM;
        end
        S_P_SUM: begin
          w_a   <= w_p + w_v1 + w_v2;
          state <= S_P_FIN;
        end
        S_P_FIN: begin
          w_sq  <= asr64(w_a, 6'd8) + (p7 << 4);
          state <= S_P_SAT;
        end
        S_P_SAT: begin
          if ($signed(w_sq) < -64'sd2147483648) begin
            res.press_q8 <= 32'h8000_0000;
          end else if ($signed(w_sq) > 64'sd2147483647) begin
            res.press_q8 <= 32'h7FFF_FFFF;
          end else begin
            res.press_q8 <= w_sq[31:0];
          end
          state <= S_H_INIT;
        end
        S_H_INIT: begin
          if (rh == HUMID_OFF_MARK) begin
            state <= S_DONE;
          end else begin
            hv    <= fine_temp - 32'd76800;
            state <= S_H_A;
          end
        end
        S_H_A: if (mul_done) begin
          hx <= asr32({2'b0, rh, 14'b0} - {h4, 20'b0} - m32 + 32'd16384, 5'd15);
          state <= S_H_B;
        end
        S_H_B: if (mul_done) begin
          hy <= asr32(m32, 5'd10);
          state <= S_H_C;
        end
        S_H_C: if (mul_done) begin
          hz <= asr32(m32, 5'd11) + 32'd32768;
          state <= S_H_D;
        end
        S_H_D: if (mul_done) begin
          hw <= asr32(m32, 5'd10) + 32'd2097152;
          state <= S_H_E;
        end
        S_H_E: if (mul_done) begin
          hw <= asr32(m32 + 32'd8192, 5'd14);
          state <= S_H_F;
        end
        S_H_F: if (mul_done) begin
          hv <= m32;
          state <= S_H_G;
        end
        S_H_G: if (mul_done) begin
          hy <= asr32(m32, 5'd7);
          state <= S_H_H;
        end
        S_H_H: if (mul_done) begin
          hv <= hv - asr32(m32, 5'd4);
          state <= S_H_CLAMP;
        end
        S_H_CLAMP: begin
          if (hv[31]) begin
            res.humid_q10 <= '0;
          end else if (hv > HUMID_MAX) begin
            res.humid_q10 <= HUMID_Q10_MAX;
          end else begin
            res.humid_q10 <= hv[28:12];
          end
          res.humid_valid <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: if (!out_valid || out_ready) begin
          out_data  <= res;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/hptc_check.sv
`default_nettype none
module hptc_check import hptc_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // An accepted item keeps the sequencer busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_humid_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.humid_q10 <= HUMID_Q10_MAX)
    else $error("humidity above full scale");

  // A skipped pressure reading carries neither a value nor a divisor flag.
  a_press_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.press_valid |->
      !out_data.press_div_zero && out_data.press_q8 == 32'sd0)
    else $error("skipped pressure has data");

  a_temp_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.temp_valid |-> out_data.temp_centi == 32'sd0)
    else $error("skipped temperature has data");

endmodule

bind humidity_pressure_temp_compensation hptc_check u_hptc_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// File: test/humidity_pressure_temp_compensation_tb.sv
`default_nettype none
module humidity_pressure_temp_compensation_tb;
  import hptc_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  humidity_pressure_temp_compensation dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Coefficient copies and kept fine temperature of the predictor.
  logic [47:0] temp_k;
  logic [63:0] press_lo_k;
  logic [63:0] press_hi_k;
  logic [47:0] mixed_k;
  logic [31:0] humid_k;
  logic signed [31:0] fine_t;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned accepted;
  bit in_quiet;
  bit out_quiet;
  bit hold_off;

  function automatic out_item_t compensate(in_item_t it);
    out_item_t r;
    logic signed [31:0] adc, a, b, t1, t2, t3, v1, v2, f;
    logic signed [31:0] v, x, y, z, w, s, h1, h2, h3, h4, h5, h6, rh;
    logic signed [63:0] pv1, pv2, p, q, pn, pd, mn, md, uq;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, padc;
    r = '0;
    if (it.raw_temp != TEMP_OFF_MARK) begin
      adc = {8'd0, it.raw_temp} >>> 4;
      t1 = {16'd0, temp_k[15:0]};
      t2 = {{16{temp_k[31]}}, temp_k[31:16]};
      t3 = {{16{temp_k[47]}}, temp_k[47:32]};
      a = (adc >>> 3) - (t1 <<< 1);
      v1 = (a * t2) >>> 11;
      b = (adc >>> 4) - t1;
      v2 = (((b * b) >>> 12) * t3) >>> 14;
      fine_t = v1 + v2;
      f = fine_t * 32'sd5 + 32'sd128;
      r.temp_centi = f >>> 8;
      r.temp_valid = 1'b1;
    end
    if (it.raw_press != PRESS_OFF_MARK) begin
      padc = {44'd0, it.raw_press[23:4]};
      p1 = {48'd0, press_lo_k[15:0]};
      p2 = {{48{press_lo_k[31]}}, press_lo_k[31:16]};
      p3 = {{48{press_lo_k[47]}}, press_lo_k[47:32]};
      p4 = {{48{press_lo_k[63]}}, press_lo_k[63:48]};
      p5 = {{48{press_hi_k[15]}}, press_hi_k[15:0]};
      p6 = {{48{press_hi_k[31]}}, press_hi_k[31:16]};
      p7 = {{48{press_hi_k[47]}}, press_hi_k[47:32]};
      p8 = {{48{press_hi_k[63]}}, press_hi_k[63:48]};
      p9 = {{48{mixed_k[15]}}, mixed_k[15:0]};
      pv1 = 64'(fine_t) - 64'sd128000;
      pv2 = pv1 * pv1 * p6;
      pv2 = pv2 + ((pv1 * p5) <<< 17);
      pv2 = pv2 + (p4 <<< 35);
      pv1 = ((pv1 * pv1 * p3) >>> 8) + ((pv1 * p2) <<< 12);
      pv1 = (((64'sd1 <<< 47) + pv1) * p1) >>> 33;
      r.press_valid = 1'b1;
      if (pv1 == 0) begin
        r.press_div_zero = 1'b1;
      end else begin
        p = 64'sd1048576 - padc;
        pn = ((p <<< 31) - pv2) * 64'sd3125;
        pd = pv1;
        // Magnitudes divided unsigned so that the most negative value wraps.
        mn = pn[63] ? -pn : pn;
        md = pd[63] ? -pd : pd;
        uq = $signed($unsigned(mn) / $unsigned(md));
        p = (pn[63] != pd[63]) ? -uq : uq;
        q = p >>> 13;
        pv1 = (p9 * q * q) >>> 25;
        pv2 = (p8 * p) >>> 19;
        p = ((p + pv1 + pv2) >>> 8) + (p7 <<< 4);
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        else if (p > 64'sd2147483647) p = 64'sd2147483647;
        r.press_q8 = p[31:0];
      end
    end
    if (it.raw_humid != HUMID_OFF_MARK) begin
      h1 = {24'd0, mixed_k[23:16]};
      h2 = {{16{mixed_k[39]}}, mixed_k[39:24]};
      h3 = {24'd0, mixed_k[47:40]};
      h4 = {{20{humid_k[11]}}, humid_k[11:0]};
      h5 = {{20{humid_k[23]}}, humid_k[23:12]};
      h6 = {{24{humid_k[31]}}, humid_k[31:24]};
      v = fine_t - 32'sd76800;
      x = ({16'd0, it.raw_humid} <<< 14) - (h4 <<< 20) - h5 * v + 32'sd16384;
      x = x >>> 15;
      y = (v * h6) >>> 10;
      z = ((v * h3) >>> 11) + 32'sd32768;
      w = ((y * z) >>> 10) + 32'sd2097152;
      w = (w * h2 + 32'sd8192) >>> 14;
      v = x * w;
      s = v >>> 15;
      s = (s * s) >>> 7;
      rh = v - ((s * h1) >>> 4);
      if (rh < 0) rh = 0;
      else if (rh > $signed(HUMID_MAX)) rh = $signed(HUMID_MAX);
      r.humid_q10 = rh[28:12];
      r.humid_valid = 1'b1;
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Driver: offers the oldest pending item; the prediction is made on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(compensate(in_data));
        accepted++;
        void'(pending_items.pop_front());
      end
      if (in_valid && !in_ready) begin
        // Hold the item until it is taken.
      end else if (pending_items.size() > 0 &&
                   (in_quiet || $urandom_range(99) >= 17)) begin
        in_valid <= 1'b1;
        in_data <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result with the oldest prediction.
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no prediction waiting");
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_data.temp_centi !== e.temp_centi) begin
            $error("temp_centi exp %0d got %0d", e.temp_centi, out_data.temp_centi);
            errors++;
          end
          if (out_data.temp_valid !== e.temp_valid) begin
            $error("temp_valid exp %0d got %0d", e.temp_valid, out_data.temp_valid);
            errors++;
          end
          if (out_data.press_q8 !== e.press_q8) begin
            $error("press_q8 exp %0d got %0d", e.press_q8, out_data.press_q8);
            errors++;
          end
          if (out_data.press_valid !== e.press_valid) begin
            $error("press_valid exp %0d got %0d", e.press_valid, out_data.press_valid);
            errors++;
          end
          if (out_data.press_div_zero !== e.press_div_zero) begin
            $error("press_div_zero exp %0d got %0d", e.press_div_zero,
                   out_data.press_div_zero);
            errors++;
          end
          if (out_data.humid_q10 !== e.humid_q10) begin
            $error("humid_q10 exp %0d got %0d", e.humid_q10, out_data.humid_q10);
            errors++;
          end
          if (out_data.humid_valid !== e.humid_valid) begin
            $error("humid_valid exp %0d got %0d", e.humid_valid, out_data.humid_valid);
            errors++;
          end
        end
      end
      out_ready <= !hold_off && (out_quiet || $urandom_range(99) >= 17);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_TEMP:       temp_k = val[47:0];
      REG_PRESS_LOW:  press_lo_k = val;
      REG_PRESS_HIGH: press_hi_k = val;
      REG_MIXED:      mixed_k = val[47:0];
      default:        humid_k = val[31:0];
    endcase
  endtask

  task automatic write_all(input logic [47:0] t, input logic [63:0] pl,
                           input logic [63:0] ph, input logic [47:0] m,
                           input logic [31:0] h);
    write_reg(REG_TEMP, {16'd0, t});
    write_reg(REG_PRESS_LOW, pl);
    write_reg(REG_PRESS_HIGH, ph);
    write_reg(REG_MIXED, {16'd0, m});
    write_reg(REG_HUMID, {32'd0, h});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Typical trim values of a real part, so results land in the normal ranges.
  function automatic void typical_set(output logic [47:0] t, output logic [63:0] pl,
                                      output logic [63:0] ph, output logic [47:0] m,
                                      output logic [31:0] h);
    t  = {16'd50, 16'd26435, 16'd27504};
    pl = {16'd2855, 16'hD0B5, 16'hD3A2 + 16'($urandom_range(200)), 16'd36477};
    ph = {16'hE83C, 16'd15500, 16'hFFF9, 16'd140};
    m  = {8'd0, 16'd361, 8'd75, 16'd6000};
    h  = {8'd30, 12'd50, 12'd330};
  endfunction

  task automatic queue_item(input logic [23:0] t, input logic [23:0] p,
                            input logic [15:0] h);
    in_item_t it;
    it.raw_temp = t;
    it.raw_press = p;
    it.raw_humid = h;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    logic [23:0] t, p;
    logic [15:0] h;
    for (int i = 0; i < n; i++) begin
      t = 24'($urandom_range(300000, 700000));
      p = 24'($urandom_range(200000, 600000));
      h = 16'($urandom_range(20000, 40000));
      case ($urandom_range(9))
        0: t = 24'($urandom());
        1: p = 24'($urandom());
        2: h = 16'($urandom());
        3: t = TEMP_OFF_MARK;
        4: p = PRESS_OFF_MARK;
        5: h = HUMID_OFF_MARK;
        default: ;
      endcase
      queue_item(t, p, h);
    end
  endtask

  initial begin
    logic [47:0] t;
    logic [63:0] pl, ph;
    logic [47:0] m;
    logic [31:0] h;
    errors = 0;
    accepted = 0;
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    hold_off = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_TEMP;
    cfg_data = '0;
    temp_k = '0;
    press_lo_k = '0;
    press_hi_k = '0;
    mixed_k = '0;
    humid_k = '0;
    fine_t = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset coefficients: pressure divisor is zero, all-zero sums elsewhere.
    queue_item(24'd519888, 24'd415148, 16'd30000);
    queue_item(TEMP_OFF_MARK, PRESS_OFF_MARK, HUMID_OFF_MARK);
    drain();

    typical_set(t, pl, ph, m, h);
    write_all(t, pl, ph, m, h);
    // Pressure and humidity before any temperature use the kept fine value.
    queue_item(TEMP_OFF_MARK, 24'd415148, 16'd30000);
    queue_item(24'd519888, 24'd415148, 16'd30000);
    queue_item(TEMP_OFF_MARK, 24'd0, 16'd0);
    queue_item(24'd0, 24'hFFFFFF, 16'hFFFF);
    queue_item(24'hFFFFFF, 24'd0, 16'd0);
    queue_item(24'h7FFFFF, 24'h800001, 16'h7FFF);
    queue_item(24'h800001, 24'h7FFFFF, 16'h8001);
    queue_item(24'd519888, PRESS_OFF_MARK, 16'd65000);
    queue_item(24'd519888, 24'd415148, HUMID_OFF_MARK);
    queue_item(24'd519888, 24'd415148, 16'd100);
    drain();

    // Extremes of every coefficient, then all ones.
    write_all(48'h7FFF_8000_FFFF, 64'h7FFF_8000_7FFF_FFFF, 64'h8000_7FFF_8000_7FFF,
              48'hFF_7FFF_FF_8000, 32'h7F_800_7FF);
    queue_item(24'd0, 24'd0, 16'd0);
    queue_item(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    queue_item(24'd519888, 24'd415148, 16'd30000);
    drain();
    write_all('1, '1, '1, '1, '1);
    queue_item(24'd0, 24'd0, 16'd0);
    queue_item(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    queue_item(24'd519888, 24'd415148, 16'd30000);
    drain();

    // Random coefficient words, including a divisor that can vanish.
    write_all(rand64(), rand64(), rand64(), rand64(), rand64());
    queue_random(120);
    drain();

    typical_set(t, pl, ph, m, h);
    write_all(t, pl, ph, m, h);
    // No idling on either side for a stretch.
    in_quiet = 1'b1;
    out_quiet = 1'b1;
    queue_random(120);
    drain();
    in_quiet = 1'b0;
    out_quiet = 1'b0;

    // Receiver stalls while the sender keeps offering items.
    queue_random(30);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
    drain();

    for (int ph_i = 0; ph_i < 8; ph_i++) begin
      typical_set(t, pl, ph, m, h);
      if (ph_i[0]) t[47:32] = 16'($urandom());
      if (ph_i[1]) m = 48'(rand64());
      if (ph_i == 7) ph = rand64();
      write_all(t, pl, ph, m, h);
      queue_random(120);
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
